[rtl/aar_pkg.sv]
// Shared constants, stage types and arithmetic helpers for the axis-angle rotation block.
package aar_pkg;

  // Output format
  localparam int OUT_FRAC_BITS = 16;
  localparam int OUT_W         = 18;
  localparam int QB            = 30;

  // Chain lengths
  localparam int CORDIC_STEPS = 23;
  localparam int SQRT_STEPS   = 32;
  localparam int DIV_STEPS    = 31;

  // Angle reduction, 1/64 degree units
  localparam int FULL_TURN    = 23040;
  localparam int HALF_TURN    = 11520;
  localparam int QUARTER_TURN = 5760;

  // Datapath widths
  localparam int XW = 32;  // cordic x/y, Q30
  localparam int ZW = 28;  // cordic angle, 2^-16 degree
  localparam int SW = 64;  // square root remainder/root
  localparam int DW = 61;  // divide remainder
  localparam int LW = 31;  // axis length
  localparam int QW = 31;  // unit component magnitude
  localparam int AW = 34;  // multiplier left operand
  localparam int UW = 32;  // signed unit component
  localparam int PW = 40;  // entry sums

  localparam int SH = QB - OUT_FRAC_BITS;

  localparam logic signed [XW-1:0] CORDIC_X0 = 32'sd652032874;
  localparam logic signed [AW-1:0] ONE_Q     = AW'(64'sd1 <<< QB);
  localparam logic signed [PW-1:0] RND       = PW'((64'sd1 <<< SH) >>> 1);
  localparam logic signed [PW-1:0] LIM       = PW'(64'sd1 <<< OUT_FRAC_BITS);
  localparam logic [OUT_W-1:0]     ONE_OUT   = LIM[OUT_W-1:0];

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic [SW-1:0] rem;
    logic [SW-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QW-1:0] quo;
    logic [LW-1:0] len;
  } div_t;

  typedef struct packed {
    logic [2:0]            sgn;
    logic                  zero;
    logic                  neg;
    logic [2:0][15:0]      mag;
    logic signed [XW-1:0]  c;
    logic signed [XW-1:0]  s;
  } side_t;

  // atan(2^-i) in 2^-16 degree
  function automatic logic signed [ZW-1:0] atan_deg16(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:  v = 28'sd2949120;
      5'd1:  v = 28'sd1740967;
      5'd2:  v = 28'sd919879;
      5'd3:  v = 28'sd466945;
      5'd4:  v = 28'sd234379;
      5'd5:  v = 28'sd117304;
      5'd6:  v = 28'sd58666;
      5'd7:  v = 28'sd29335;
      5'd8:  v = 28'sd14668;
      5'd9:  v = 28'sd7334;
      5'd10: v = 28'sd3667;
      5'd11: v = 28'sd1833;
      5'd12: v = 28'sd917;
      5'd13: v = 28'sd458;
      5'd14: v = 28'sd229;
      5'd15: v = 28'sd115;
      5'd16: v = 28'sd57;
      5'd17: v = 28'sd29;
      5'd18: v = 28'sd14;
      5'd19: v = 28'sd7;
      5'd20: v = 28'sd4;
      5'd21: v = 28'sd2;
      5'd22: v = 28'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Partial product against the low 16 bits of b (unsigned)
  function automatic logic signed [AW+16:0] mul_lo(input logic signed [AW-1:0] a,
                                                   input logic signed [UW-1:0] b);
    logic signed [AW+16:0] p;
    p = a * $signed({1'b0, b[15:0]});
    return p;
  endfunction

  // Partial product against the high half of b (signed)
  function automatic logic signed [AW+15:0] mul_hi(input logic signed [AW-1:0] a,
                                                   input logic signed [UW-1:0] b);
    logic signed [AW+15:0] p;
    p = a * $signed(b[UW-1:16]);
    return p;
  endfunction

  // Join partials and floor-shift back to Q30
  function automatic logic signed [AW-1:0] mul_join(input logic signed [AW+15:0] ph,
                                                    input logic signed [AW+16:0] pl);
    logic signed [AW+UW-1:0] full;
    full = ((AW+UW)'(ph) <<< 16) + (AW+UW)'(pl);
    return AW'(full >>> QB);
  endfunction

  // Round half up, saturate, mask to port width
  function automatic logic [OUT_W-1:0] to_out(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] r;
    r = (v + RND) >>> SH;
    if (r > LIM) r = LIM;
    else if (r < -LIM) r = -LIM;
    return r[OUT_W-1:0];
  endfunction

endpackage

[rtl/axis_angle_rotation_matrix.sv]
// Top level: angle reduction, CORDIC/sqrt/divide cell chains, product tail, output register.
// Throughput: one beat per cycle unless a held result stalls the chain;
// the depth is set by the 32-cell square root chain followed by the 31-cell divide
// chains, the 23-cell CORDIC runs beside the root.
// A held result stalls the whole chain; in_stall follows a full, stalled output.
// Reset (rst_n low, synchronous) clears all stage valid bits; no memories to clear.
module axis_angle_rotation_matrix (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_angle,
  input  logic signed [15:0] in_axis_x,
  input  logic signed [15:0] in_axis_y,
  input  logic signed [15:0] in_axis_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [17:0] out_r00,
  output logic signed [17:0] out_r01,
  output logic signed [17:0] out_r02,
  output logic signed [17:0] out_r10,
  output logic signed [17:0] out_r11,
  output logic signed [17:0] out_r12,
  output logic signed [17:0] out_r20,
  output logic signed [17:0] out_r21,
  output logic signed [17:0] out_r22,
  output logic               out_zero_axis
);
  import aar_pkg::*;

  localparam int DIV_END = SQRT_STEPS + DIV_STEPS;
  localparam int ST_U    = DIV_END + 1;
  localparam int LAST    = DIV_END + 6;

  logic              en;
  logic [LAST:0]     vld_r;

  // stage 0 front end
  logic signed [16:0] ae, r0, r1;
  logic               neg0;
  logic signed [31:0] sqx, sqy, sqz;
  logic [31:0]        n2;
  cordic_t            cd0_nxt, cd0_r;
  sqrt_t              sq0_nxt, sq0_r;
  side_t              sd0_nxt;

  cordic_t cd [0:CORDIC_STEPS];
  sqrt_t   sq [0:SQRT_STEPS];
  div_t    dv [0:2][0:DIV_STEPS];
  side_t   sd_r [0:DIV_END];
  side_t   sd_nxt [1:DIV_END];

  // tail
  logic signed [UW-1:0]   u_nxt [0:2];
  logic signed [UW-1:0]   u_r [ST_U:ST_U+2][0:2];
  logic signed [AW-1:0]   t_r;
  logic signed [AW-1:0]   s_r [ST_U:ST_U+2];
  logic signed [XW-1:0]   c_r [ST_U:ST_U+4];
  logic                   z_r [ST_U:ST_U+4];
  logic signed [AW+15:0]  ph_r [0:2];
  logic signed [AW+16:0]  pl_r [0:2];
  logic signed [AW-1:0]   tv_r [0:2];
  logic signed [AW-1:0]   ma [0:8];
  logic signed [UW-1:0]   mb [0:8];
  logic signed [AW+15:0]  qh_r [0:8];
  logic signed [AW+16:0]  ql_r [0:8];
  logic signed [AW-1:0]   pr_r [0:8];
  logic signed [PW-1:0]   e [0:8];
  logic [OUT_W-1:0]       ent_r [0:8];
  logic                   zero_r;

  // global advance: the chain moves unless a held result blocks it
  assign in_stall  = vld_r[LAST] & out_stall;
  assign en        = ~in_stall;
  assign out_valid = vld_r[LAST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAST-1:0], in_valid};
    end
  end

  // angle reduction into [-90, 90] plus sign fold, squares, magnitudes
  always_comb begin
    ae   = {in_angle[15], in_angle};
    neg0 = 1'b0;
    if (ae > 17'(HALF_TURN))        r0 = ae - 17'(FULL_TURN);
    else if (ae <= -17'(HALF_TURN)) r0 = ae + 17'(FULL_TURN);
    else                            r0 = ae;
    r1 = r0;
    if (r0 > 17'(QUARTER_TURN)) begin
      r1   = r0 - 17'(HALF_TURN);
      neg0 = 1'b1;
    end else if (r0 < -17'(QUARTER_TURN)) begin
      r1   = r0 + 17'(HALF_TURN);
      neg0 = 1'b1;
    end
    cd0_nxt.x = CORDIC_X0;
    cd0_nxt.y = '0;
    cd0_nxt.z = ZW'(r1) <<< 10;

    sqx = in_axis_x * in_axis_x;
    sqy = in_axis_y * in_axis_y;
    sqz = in_axis_z * in_axis_z;
    n2  = $unsigned(sqx) + $unsigned(sqy) + $unsigned(sqz);
    sq0_nxt.rem  = SW'(n2) << 28;
    sq0_nxt.root = '0;

    sd0_nxt.sgn    = {in_axis_z[15], in_axis_y[15], in_axis_x[15]};
    sd0_nxt.zero   = (in_axis_x == 16'sd0) && (in_axis_y == 16'sd0) && (in_axis_z == 16'sd0);
    sd0_nxt.neg    = neg0;
    sd0_nxt.mag[0] = in_axis_x[15] ? 16'(-in_axis_x) : 16'(in_axis_x);
    sd0_nxt.mag[1] = in_axis_y[15] ? 16'(-in_axis_y) : 16'(in_axis_y);
    sd0_nxt.mag[2] = in_axis_z[15] ? 16'(-in_axis_z) : 16'(in_axis_z);
    sd0_nxt.c      = '0;
    sd0_nxt.s      = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cd0_r    <= cd0_nxt;
      sq0_r    <= sq0_nxt;
      sd_r[0]  <= sd0_nxt;
    end
  end

  assign cd[0] = cd0_r;
  assign sq[0] = sq0_r;

  // CORDIC chain
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    aar_cordic_cell u_cell (
      .clk  (clk),
      .en   (en),
      .step (5'(i)),
      .d_in (cd[i]),
      .d_out(cd[i+1])
    );
  end

  // square root chain
  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    aar_sqrt_cell u_cell (
      .clk  (clk),
      .en   (en),
      .step (5'(SQRT_STEPS-1-i)),
      .d_in (sq[i]),
      .d_out(sq[i+1])
    );
  end

  // side data delay line; cos/sin join it after the CORDIC
  for (genvar k = 1; k <= DIV_END; k++) begin : g_side
    always_comb begin
      sd_nxt[k] = sd_r[k-1];
      if (k == CORDIC_STEPS + 1) begin
        sd_nxt[k].c = sd_r[k-1].neg ? -cd[CORDIC_STEPS].x : cd[CORDIC_STEPS].x;
        sd_nxt[k].s = sd_r[k-1].neg ? -cd[CORDIC_STEPS].y : cd[CORDIC_STEPS].y;
      end
    end
    always_ff @(posedge clk) begin
      if (en) sd_r[k] <= sd_nxt[k];
    end
  end

  // three divide lanes: round(|v| * 2^44 / len)
  for (genvar l = 0; l < 3; l++) begin : g_lane
    always_comb begin
      dv[l][0].len = sq[SQRT_STEPS].root[LW-1:0];
      dv[l][0].quo = '0;
      dv[l][0].rem = (DW'(sd_r[SQRT_STEPS].mag[l]) << 44)
                   + DW'(sq[SQRT_STEPS].root[LW-1:0] >> 1);
    end
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      aar_div_cell u_cell (
        .clk  (clk),
        .en   (en),
        .step (5'(DIV_STEPS-1-k)),
        .d_in (dv[l][k]),
        .d_out(dv[l][k+1])
      );
    end
    assign u_nxt[l] = sd_r[DIV_END].sgn[l] ? -$signed({1'b0, dv[l][DIV_STEPS].quo})
                                           : $signed({1'b0, dv[l][DIV_STEPS].quo});
  end

  // product pairing for the second multiply layer
  always_comb begin
    ma[0] = tv_r[0]; mb[0] = u_r[ST_U+2][0];
    ma[1] = tv_r[0]; mb[1] = u_r[ST_U+2][1];
    ma[2] = tv_r[0]; mb[2] = u_r[ST_U+2][2];
    ma[3] = tv_r[1]; mb[3] = u_r[ST_U+2][1];
    ma[4] = tv_r[1]; mb[4] = u_r[ST_U+2][2];
    ma[5] = tv_r[2]; mb[5] = u_r[ST_U+2][2];
    ma[6] = s_r[ST_U+2]; mb[6] = u_r[ST_U+2][0];
    ma[7] = s_r[ST_U+2]; mb[7] = u_r[ST_U+2][1];
    ma[8] = s_r[ST_U+2]; mb[8] = u_r[ST_U+2][2];
  end

  // tail: unit vector, t*u, then the nine products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        u_r[ST_U][l]   <= u_nxt[l];
        u_r[ST_U+1][l] <= u_r[ST_U][l];
        u_r[ST_U+2][l] <= u_r[ST_U+1][l];
        ph_r[l]        <= mul_hi(t_r, u_r[ST_U][l]);
        pl_r[l]        <= mul_lo(t_r, u_r[ST_U][l]);
        tv_r[l]        <= mul_join(ph_r[l], pl_r[l]);
      end
      t_r          <= ONE_Q - AW'(sd_r[DIV_END].c);
      s_r[ST_U]    <= AW'(sd_r[DIV_END].s);
      s_r[ST_U+1]  <= s_r[ST_U];
      s_r[ST_U+2]  <= s_r[ST_U+1];
      c_r[ST_U]    <= sd_r[DIV_END].c;
      z_r[ST_U]    <= sd_r[DIV_END].zero;
      for (int k = ST_U + 1; k <= ST_U + 4; k++) begin
        c_r[k] <= c_r[k-1];
        z_r[k] <= z_r[k-1];
      end
      for (int j = 0; j < 9; j++) begin
        qh_r[j] <= mul_hi(ma[j], mb[j]);
        ql_r[j] <= mul_lo(ma[j], mb[j]);
        pr_r[j] <= mul_join(qh_r[j], ql_r[j]);
      end
    end
  end

  // entry sums
  always_comb begin
    e[0] = PW'(pr_r[0]) + PW'(c_r[ST_U+4]);
    e[1] = PW'(pr_r[1]) + PW'(pr_r[8]);
    e[2] = PW'(pr_r[2]) - PW'(pr_r[7]);
    e[3] = PW'(pr_r[1]) - PW'(pr_r[8]);
    e[4] = PW'(pr_r[3]) + PW'(c_r[ST_U+4]);
    e[5] = PW'(pr_r[4]) + PW'(pr_r[6]);
    e[6] = PW'(pr_r[2]) + PW'(pr_r[7]);
    e[7] = PW'(pr_r[4]) - PW'(pr_r[6]);
    e[8] = PW'(pr_r[5]) + PW'(c_r[ST_U+4]);
  end

  // output register; zero axis gives identity
  always_ff @(posedge clk) begin
    if (en) begin
      zero_r <= z_r[ST_U+4];
      for (int j = 0; j < 9; j++) begin
        if (z_r[ST_U+4]) ent_r[j] <= (j % 4 == 0) ? ONE_OUT : '0;
        else             ent_r[j] <= to_out(e[j]);
      end
    end
  end

  assign out_r00       = $signed(ent_r[0]);
  assign out_r01       = $signed(ent_r[1]);
  assign out_r02       = $signed(ent_r[2]);
  assign out_r10       = $signed(ent_r[3]);
  assign out_r11       = $signed(ent_r[4]);
  assign out_r12       = $signed(ent_r[5]);
  assign out_r20       = $signed(ent_r[6]);
  assign out_r21       = $signed(ent_r[7]);
  assign out_r22       = $signed(ent_r[8]);
  assign out_zero_axis = zero_r;

  // chain only blocks behind a held result
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled without a held result");

  // stage valids freeze while blocked
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved while blocked");

  // zero axis beat carries identity
  a_zero_ident: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_axis) |->
      (ent_r[0] == ONE_OUT && ent_r[4] == ONE_OUT && ent_r[8] == ONE_OUT &&
       ent_r[1] == '0 && ent_r[5] == '0))
    else $error("zero axis result is not identity");
endmodule

[rtl/aar_cordic_cell.sv]
// One rotation-mode CORDIC micro-rotation with its output register.
module aar_cordic_cell (
  input  logic             clk,
  input  logic             en,
  input  logic [4:0]       step,
  input  aar_pkg::cordic_t d_in,
  output aar_pkg::cordic_t d_out
);
  import aar_pkg::*;

  cordic_t              d_r, d_nxt;
  logic signed [XW-1:0] dx, dy;
  logic signed [ZW-1:0] at;

  // rotate toward zero residual angle
  always_comb begin
    dx    = d_in.y >>> step;
    dy    = d_in.x >>> step;
    at    = atan_deg16(step);
    d_nxt = d_in;
    if (d_in.z >= 0) begin
      d_nxt.x = d_in.x - dx;
      d_nxt.y = d_in.y + dy;
      d_nxt.z = d_in.z - at;
    end else begin
      d_nxt.x = d_in.x + dx;
      d_nxt.y = d_in.y - dy;
      d_nxt.z = d_in.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_r <= d_nxt;
  end

  assign d_out = d_r;
endmodule

[rtl/aar_sqrt_cell.sv]
// One digit step of the integer square root with its output register.
module aar_sqrt_cell (
  input  logic           clk,
  input  logic           en,
  input  logic [4:0]     step,
  input  aar_pkg::sqrt_t d_in,
  output aar_pkg::sqrt_t d_out
);
  import aar_pkg::*;

  sqrt_t         d_r, d_nxt;
  logic [SW-1:0] pw, trial;

  // trial subtract of root + 4^step
  always_comb begin
    pw    = SW'(1) << {step, 1'b0};
    trial = d_in.root + pw;
    d_nxt = d_in;
    if (d_in.rem >= trial) begin
      d_nxt.rem  = d_in.rem - trial;
      d_nxt.root = (d_in.root >> 1) + pw;
    end else begin
      d_nxt.root = d_in.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_r <= d_nxt;
  end

  assign d_out = d_r;
endmodule

[rtl/aar_div_cell.sv]
// One restoring-divide quotient bit with its output register.
module aar_div_cell (
  input  logic          clk,
  input  logic          en,
  input  logic [4:0]    step,
  input  aar_pkg::div_t d_in,
  output aar_pkg::div_t d_out
);
  import aar_pkg::*;

  div_t          d_r, d_nxt;
  logic [DW-1:0] dsr;

  // compare against len shifted to this quotient bit
  always_comb begin
    dsr   = DW'(d_in.len) << step;
    d_nxt = d_in;
    if (d_in.rem >= dsr) begin
      d_nxt.rem = d_in.rem - dsr;
      d_nxt.quo = d_in.quo | (QW'(1) << step);
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_r <= d_nxt;
  end

  assign d_out = d_r;
endmodule
